// ===== rtl/core/fpw_pkg.sv =====
// Package with the shared types and constants of the framed pixel write parser.
package fpw_pkg;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_ADDRH = 3'd1,
		PH_ADDRL = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4
	} phase_t;

	typedef enum logic {
		REG_SYNC_BYTE  = 1'b0,
		REG_MAX_LENGTH = 1'b1
	} reg_index_t;

	localparam logic [7:0] SYNC_BYTE_RESET  = 8'hFA;
	localparam logic [7:0] MAX_LENGTH_RESET = 8'd32;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] mem_row;
		logic [7:0] mem_column;
		logic [3:0] nibble;
		logic       pair_last;
		logic       command_end;
	} out_item_t;

endpackage

// ===== rtl/core/fpw_stream_if.sv =====
// Valid/ready stream interface that carries one payload per transaction.
interface fpw_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/framed_pixel_write_parser.sv =====
// Top level of the framed pixel write parser: byte stream in, nibble writes out.
// Flow: an accepted data byte is registered in the pair register, which presents its high
// nibble write and then, once that write is taken, its low nibble write; the output may stall.
// Throughput: one nibble write per cycle unless the output stalls; the next data byte is
// taken as the last low nibble write goes; sync, address and length bytes one per cycle.
// Reset: arst_n clears the parser to sync hunting, the pending write pair to empty and the
// registers to sync byte 250 and maximum length 32.
module framed_pixel_write_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	fpw_stream_if.sink                in_ch,
	fpw_stream_if.source              out_ch,
	input  logic                      cfg_we,
	input  fpw_pkg::reg_index_t       cfg_index,
	input  logic [7:0]                cfg_wdata
);

	fpw_pkg::phase_t phase_q, phase_d;
	logic [7:0]      sync_byte_q;
	logic [7:0]      max_length_q;
	logic [15:0]     addr_q;
	logic [7:0]      bytes_left_q;
	logic [7:0]      row_q;
	logic [7:0]      column_q;

	logic            pair_valid_s1;
	logic            half_s1;
	logic [7:0]      row_s1;
	logic [7:0]      column_s1;
	logic [7:0]      byte_s1;
	logic            end_s1;

	logic            in_fire;
	logic            out_fire;
	logic            pair_done;
	logic            data_fire;
	logic [7:0]      b;
	logic            len_bad;
	logic [7:0]      bytes_left_dec;

	assign b              = in_ch.payload.data_byte;
	assign out_fire       = out_ch.valid && out_ch.ready;
	assign pair_done      = out_fire && half_s1;
	assign in_fire        = in_ch.valid && in_ch.ready;
	assign data_fire      = in_fire && (phase_q == fpw_pkg::PH_DATA);
	assign len_bad        = (b == 8'd0) || (b > max_length_q);
	assign bytes_left_dec = bytes_left_q - 8'd1;

	// Only a data byte needs the pair register; other bytes pass while a pair drains.
	assign in_ch.ready = (phase_q != fpw_pkg::PH_DATA) || !pair_valid_s1 || pair_done;

	always_comb begin
		phase_d = phase_q;
		if (in_fire) begin
			case (phase_q)
				fpw_pkg::PH_HUNT: begin
					if (b == sync_byte_q) phase_d = fpw_pkg::PH_ADDRH;
				end
				fpw_pkg::PH_ADDRH: phase_d = fpw_pkg::PH_ADDRL;
				fpw_pkg::PH_ADDRL: phase_d = fpw_pkg::PH_LEN;
				fpw_pkg::PH_LEN: begin
					phase_d = len_bad ? fpw_pkg::PH_HUNT : fpw_pkg::PH_DATA;
				end
				fpw_pkg::PH_DATA: begin
					if (bytes_left_dec == 8'd0) phase_d = fpw_pkg::PH_HUNT;
				end
				default: phase_d = fpw_pkg::PH_HUNT;
			endcase
		end
	end

	always_comb begin
		out_ch.valid               = pair_valid_s1;
		out_ch.payload.mem_row     = row_s1;
		out_ch.payload.mem_column  = column_s1 + {7'd0, half_s1};
		out_ch.payload.nibble      = half_s1 ? byte_s1[3:0] : byte_s1[7:4];
		out_ch.payload.pair_last   = half_s1;
		out_ch.payload.command_end = end_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= fpw_pkg::PH_HUNT;
			sync_byte_q  <= fpw_pkg::SYNC_BYTE_RESET;
			max_length_q <= fpw_pkg::MAX_LENGTH_RESET;
			addr_q       <= 16'd0;
			bytes_left_q <= 8'd0;
			row_q        <= 8'd0;
			column_q     <= 8'd0;
		end else begin
			phase_q <= phase_d;
			if (cfg_we) begin
				case (cfg_index)
					fpw_pkg::REG_SYNC_BYTE:  sync_byte_q  <= cfg_wdata;
					fpw_pkg::REG_MAX_LENGTH: max_length_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (in_fire) begin
				case (phase_q)
					fpw_pkg::PH_ADDRH: addr_q <= {b, 8'd0};
					fpw_pkg::PH_ADDRL: addr_q <= {addr_q[15:8], b};
					fpw_pkg::PH_LEN: begin
						if (!len_bad) begin
							bytes_left_q <= b;
							row_q        <= addr_q[13:6];
							column_q     <= {|addr_q[15:14], addr_q[5:0], 1'b0};
						end
					end
					fpw_pkg::PH_DATA: begin
						bytes_left_q <= bytes_left_dec;
						column_q     <= column_q + 8'd2;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_s1 <= 1'b0;
			half_s1       <= 1'b0;
		end else begin
			if (data_fire) begin
				pair_valid_s1 <= 1'b1;
				half_s1       <= 1'b0;
			end else if (pair_done) begin
				pair_valid_s1 <= 1'b0;
				half_s1       <= 1'b0;
			end else if (out_fire) begin
				half_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (data_fire) begin
			row_s1    <= row_q;
			column_s1 <= column_q;
			byte_s1   <= b;
			end_s1    <= (bytes_left_dec == 8'd0);
		end
	end

	a_low_after_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !half_s1) |=> (pair_valid_s1 && half_s1))
		else $error("low nibble write did not follow the high nibble write");

	a_half_only_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(half_s1) |-> $past(out_fire))
		else $error("pair advanced without an output transaction");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid_s1 && !pair_done) |-> !data_fire)
		else $error("data byte accepted while a pending write pair was not finished");

endmodule
